// ----- design/msr_pkg.sv -----
// types and constants shared by the speed ramp frame sender
`default_nettype none

package msr_pkg;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] steer_value;
        logic signed [15:0] speed_value;
        logic [14:0]        ramp_ms;
        logic [31:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_item;

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_SOFT = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    typedef enum logic [1:0] {
        K_SET,
        K_SOFT,
        K_TICK
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] steer;
        logic [15:0] speed;
        logic [14:0] ramp_ms;
        logic [31:0] now_ms;
    } t_cmd;

    typedef struct packed {
        logic [15:0] steer;
        logic [15:0] speed;
    } t_frame_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_ADD,
        S_SEND
    } t_ramp_state;

    localparam int          PROD_W        = 48;
    localparam logic [5:0]  DIV_LAST      = 6'd47;
    localparam logic [2:0]  LAST_BYTE_IDX = 3'd7;
    localparam logic [15:0] MARKER_RESET  = 16'hABCD;
    localparam int          ADDR_W        = 3;
    localparam logic [0:0]  IDX_START_MARKER = 1'b0;

endpackage

`default_nettype wire

// ----- design/msr_front.sv -----
// front end: accepts items, classifies them and queues commands
`default_nettype none

module msr_front
    import msr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    output logic          o_full,
    input  wire t_in_item i_item,
    output t_cmd          o_cmd,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_take
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_q [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cmd             w_cmd;
    logic             w_known;
    logic             w_wr;
    logic             w_rd;

    always_comb begin
        w_cmd.steer   = i_item.steer_value;
        w_cmd.speed   = i_item.speed_value;
        w_cmd.ramp_ms = i_item.ramp_ms;
        w_cmd.now_ms  = i_item.now_ms;
        w_known       = 1'b1;
        case (i_item.operation)
            OP_SET:  w_cmd.kind = K_SET;
            OP_SOFT: w_cmd.kind = K_SOFT;
            OP_TICK: w_cmd.kind = K_TICK;
            default: begin
                w_cmd.kind = K_SET;
                w_known    = 1'b0;
            end
        endcase
    end

    assign o_full      = (r_cnt == CNT_FULL);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];
    // unused codes are taken and dropped
    assign w_wr        = i_push & ~o_full & w_known;
    assign w_rd        = i_cmd_take & o_cmd_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (w_rd) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- design/msr_ramp.sv -----
// back end: command state, linear ramp update with serial divide
`default_nettype none

module msr_ramp
    import msr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_take,
    output t_frame_req o_req,
    output logic      o_req_valid,
    input  wire logic i_req_ready
);

    t_ramp_state       r_state, n_state;
    logic [15:0]       r_steer, n_steer;
    logic [15:0]       r_speed, n_speed;
    logic [15:0]       r_from, n_from;
    logic [15:0]       r_to, n_to;
    logic [31:0]       r_begin, n_begin;
    logic [31:0]       r_finish, n_finish;
    logic [31:0]       r_elapsed, n_elapsed;
    logic [31:0]       r_span, n_span;
    logic [15:0]       r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [PROD_W-1:0] r_quo, n_quo;
    logic [31:0]       r_rem, n_rem;
    logic [5:0]        r_cnt, n_cnt;
    logic [PROD_W-1:0] w_prod;
    logic [16:0]       w_diff;
    logic [16:0]       w_absd;
    logic [32:0]       w_trial;
    logic [32:0]       w_sub;
    logic [15:0]       w_step;

    assign w_prod  = r_mag * r_elapsed;
    assign w_diff  = {r_to[15], r_to} - {r_from[15], r_from};
    assign w_absd  = w_diff[16] ? (17'd0 - w_diff) : w_diff;
    assign w_trial = {r_rem, r_quo[PROD_W-1]};
    assign w_sub   = w_trial - {1'b0, r_span};
    assign w_step  = r_neg ? (16'd0 - r_quo[15:0]) : r_quo[15:0];

    assign o_req.steer = r_steer;
    assign o_req.speed = r_speed;

    always_comb begin
        n_state   = r_state;
        n_steer   = r_steer;
        n_speed   = r_speed;
        n_from    = r_from;
        n_to      = r_to;
        n_begin   = r_begin;
        n_finish  = r_finish;
        n_elapsed = r_elapsed;
        n_span    = r_span;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        o_cmd_take  = 1'b0;
        o_req_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    case (i_cmd.kind)
                        K_SET: begin
                            n_from  = i_cmd.speed;
                            n_steer = i_cmd.steer;
                            n_speed = i_cmd.speed;
                        end
                        K_SOFT: begin
                            n_from   = r_speed;
                            n_to     = i_cmd.speed;
                            n_begin  = i_cmd.now_ms;
                            n_finish = i_cmd.now_ms + {17'd0, i_cmd.ramp_ms};
                            n_steer  = i_cmd.steer;
                        end
                        K_TICK: begin
                            n_state = S_SEND;
                            if (r_finish != '0) begin
                                if (i_cmd.now_ms >= r_finish) begin
                                    n_speed  = r_to;
                                    n_from   = '0;
                                    n_to     = '0;
                                    n_begin  = '0;
                                    n_finish = '0;
                                end else if (r_finish != r_begin) begin
                                    n_elapsed = i_cmd.now_ms - r_begin;
                                    n_span    = r_finish - r_begin;
                                    n_neg     = w_diff[16];
                                    n_mag     = w_absd[15:0];
                                    n_state   = S_MUL;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                n_quo   = w_prod;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!w_sub[32]) begin
                    n_rem = w_sub[31:0];
                    n_quo = {r_quo[PROD_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[31:0];
                    n_quo = {r_quo[PROD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_speed = r_from + w_step;
                n_state = S_SEND;
            end
            S_SEND: begin
                o_req_valid = 1'b1;
                if (i_req_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_steer  <= '0;
            r_speed  <= '0;
            r_from   <= '0;
            r_to     <= '0;
            r_begin  <= '0;
            r_finish <= '0;
        end else begin
            r_state  <= n_state;
            r_steer  <= n_steer;
            r_speed  <= n_speed;
            r_from   <= n_from;
            r_to     <= n_to;
            r_begin  <= n_begin;
            r_finish <= n_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elapsed <= n_elapsed;
        r_span    <= n_span;
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
    end

endmodule

`default_nettype wire

// ----- design/msr_tx.sv -----
// frame builder and byte output buffer
`default_nettype none

module msr_tx
    import msr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [15:0] i_marker,
    input  wire t_frame_req i_req,
    input  wire logic       i_req_valid,
    output logic            o_req_ready,
    output t_out_item       o_result,
    output logic            o_empty,
    input  wire logic       i_pop
);

    logic        r_busy, n_busy;
    logic [2:0]  r_idx, n_idx;
    logic [63:0] r_words;
    logic [15:0] w_neg;
    logic [15:0] w_chk;
    logic        w_load;

    assign w_neg  = 16'd0 - i_req.speed;
    assign w_chk  = i_marker ^ i_req.steer ^ w_neg;
    assign w_load = i_req_valid & ~r_busy;

    assign o_req_ready         = ~r_busy;
    assign o_empty             = ~r_busy;
    assign o_result.frame_byte = r_words[{r_idx, 3'b000} +: 8];
    assign o_result.last_byte  = (r_idx == LAST_BYTE_IDX);

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (w_load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (r_busy && i_pop) begin
            n_idx = r_idx + 1'b1;
            if (r_idx == LAST_BYTE_IDX) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_words <= {w_chk, w_neg, i_req.steer, i_marker};
        end
    end

endmodule

`default_nettype wire

// ----- design/motor_speed_ramp_frame_sender.sv -----
// top level: config register and the front, ramp and frame stages
//
//  channel   | direction | transfer when
//  ----------+-----------+------------------------------------------
//  item      | in        | push & !full
//  result    | out       | pop & !empty, one byte, 8 per tick
//  config    | in        | psel & penable & pwrite & pready
//
// set and soft items finish in the ramp idle state; unused codes never reach it
// a tick compares, then while a ramp runs: 16x32 multiply, 48-step restoring
// divide in one shared subtractor, final add, then handoff to the frame buffer
// the frame buffer holds one frame and drains one byte per pop, so the ramp
// unit keeps working while a frame waits; full rises when the queue holds DEPTH
// synchronous reset clears the command state and sets the marker to 0xabcd
`default_nettype none

module motor_speed_ramp_frame_sender
    import msr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire t_in_item          i_item,
    output logic                   empty,
    input  wire logic              pop,
    output t_out_item              o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [15:0] r_marker;
    t_cmd        w_cmd;
    logic        w_cmd_valid;
    logic        w_cmd_take;
    t_frame_req  w_req;
    logic        w_req_valid;
    logic        w_req_ready;
    logic        w_hit;

    assign pready = 1'b1;
    assign w_hit  = (paddr[ADDR_W-1:2] == IDX_START_MARKER);
    assign prdata = w_hit ? {16'd0, r_marker} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= MARKER_RESET;
        end else if (psel && penable && pwrite && w_hit) begin
            r_marker <= pwdata[15:0];
        end
    end

    msr_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_cmd      (w_cmd),
        .o_cmd_valid(w_cmd_valid),
        .i_cmd_take (w_cmd_take)
    );

    msr_ramp u_ramp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cmd_valid(w_cmd_valid),
        .o_cmd_take (w_cmd_take),
        .o_req      (w_req),
        .o_req_valid(w_req_valid),
        .i_req_ready(w_req_ready)
    );

    msr_tx u_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_marker   (r_marker),
        .i_req      (w_req),
        .i_req_valid(w_req_valid),
        .o_req_ready(w_req_ready),
        .o_result   (o_result),
        .o_empty    (empty),
        .i_pop      (pop)
    );

endmodule

`default_nettype wire
